/* sv/double_ended_priority_queue_assert.svh */
// Assertion macros for the double-ended priority queue.
// Included by double_ended_priority_queue.sv; uses its clock and reset nets.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DEPQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define DEPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/depq_pkg.sv */
// Package for the double-ended priority queue: item types, codes, states.
// No dependencies.
`default_nettype none

package depq_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int ID_W             = 20;
   localparam int PRI_W            = 24;

   typedef enum logic [1:0] {
      OP_INSERT     = 2'd0,
      OP_SERVE_HIGH = 2'd1,
      OP_SERVE_LOW  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_SERVED  = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_DROPPED = 2'd2
   } status_type;

   typedef struct packed {
      op_type             req_type;
      logic [ID_W-1:0]    client_id;
      logic [PRI_W-1:0]   priority_req;
   } req_item_type;

   typedef struct packed {
      logic [ID_W-1:0]    served_id;
      status_type         status;
   } rsp_item_type;

   // one stored entry
   typedef struct packed {
      logic [PRI_W-1:0]   pri;
      logic [ID_W-1:0]    id;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CMP,
      S_SRV_RD,
      S_SRV_OUT
   } state_type;

endpackage

`default_nettype wire

/* sv/double_ended_priority_queue.sv */
// Double-ended priority queue: sorted entry store in a ring-addressed memory.
// Depends on depq_pkg and double_ended_priority_queue_assert.svh.
`default_nettype none

`include "double_ended_priority_queue_assert.svh"

// Keeps up to CAPACITY (id, priority) entries sorted by ascending priority
// in one memory, addressed as a ring from a head pointer so that removing
// the lowest entry moves no data. An item is taken when start is high and
// busy is low. Results come on rsp_item for one cycle with rsp_strobe high
// and cannot be held off; a successful insert gives no result.
// Busy states after the accepting edge:
//   insert: a read and a compare state per stored entry moved up, then a
//     read state (stops at the head) or a compare state (stops at a lower
//     entry); the one memory read port and the single priority comparator
//     handle one stored entry at a time;
//   serve highest / lowest: memory read, then update, result strobed in
//     the cycle after that;
//   insert when full, serve when empty: no busy state, result strobed in
//     the next cycle; unused code: no busy state, no result, nothing changes.
// A new entry goes in front of stored entries with equal priority.
// The memory needs no clearing after reset: only entries below the count
// are read.
module double_ended_priority_queue #(
   parameter int CAPACITY = depq_pkg::CAPACITY_DEFAULT
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   input  depq_pkg::req_item_type  req_item,
   output logic                    busy,
   output logic                    rsp_strobe,
   output depq_pkg::rsp_item_type  rsp_item
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
   localparam logic [AW:0]   CAP_WRAP  = (AW + 1)'(CAPACITY);

   // ring address: base + offset, both below CAPACITY
   function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] base,
                                             input logic [AW-1:0] offs);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= CAP_WRAP) begin
         sum = sum - CAP_WRAP;
      end
      return sum[AW-1:0];
   endfunction

   // control state
   depq_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       head_ff, head_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   // working payload
   logic [AW-1:0]          pos_ff, pos_in;     // logical slot being filled
   depq_pkg::op_type       op_ff, op_in;
   depq_pkg::entry_type    new_ff, new_in;
   depq_pkg::rsp_item_type rsp_ff, rsp_in;

   // memory and its ports
   depq_pkg::entry_type mem [CAPACITY];
   depq_pkg::entry_type rd_data_ff;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   depq_pkg::entry_type wr_data;

   logic          accept;
   logic [CW-1:0] count_m1;

   assign busy       = (state_ff != depq_pkg::S_IDLE);
   assign accept     = start && !busy;
   assign count_m1   = count_ff - CW'(1);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         depq_pkg::S_IDLE: begin
            if (accept) begin
               case (req_item.req_type)
                  depq_pkg::OP_INSERT: begin
                     if (count_ff != CAP_COUNT) begin
                        state_in = depq_pkg::S_INS_RD;
                     end
                  end
                  depq_pkg::OP_SERVE_HIGH, depq_pkg::OP_SERVE_LOW: begin
                     if (count_ff != '0) begin
                        state_in = depq_pkg::S_SRV_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         depq_pkg::S_INS_RD: begin
            // at the head the new entry lands without a compare
            if (pos_ff == '0) begin
               state_in = depq_pkg::S_IDLE;
            end else begin
               state_in = depq_pkg::S_INS_CMP;
            end
         end
         depq_pkg::S_INS_CMP: begin
            if (rd_data_ff.pri >= new_ff.pri) begin
               state_in = depq_pkg::S_INS_RD;
            end else begin
               state_in = depq_pkg::S_IDLE;
            end
         end
         depq_pkg::S_SRV_RD:  state_in = depq_pkg::S_SRV_OUT;
         depq_pkg::S_SRV_OUT: state_in = depq_pkg::S_IDLE;
         default:             state_in = depq_pkg::S_IDLE;
      endcase
   end

   // ---------------- datapath and outputs ----------------
   always_comb begin
      count_in      = count_ff;
      head_in       = head_ff;
      pos_in        = pos_ff;
      op_in         = op_ff;
      new_in        = new_ff;
      wr_en         = 1'b0;
      wr_addr       = head_ff;
      wr_data       = new_ff;
      rd_addr       = head_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '{served_id: '0, status: depq_pkg::ST_SERVED};

      case (state_ff)
         depq_pkg::S_IDLE: begin
            if (accept) begin
               op_in  = req_item.req_type;
               new_in = '{pri: req_item.priority_req, id: req_item.client_id};
               pos_in = count_ff[AW-1:0];   // append slot; unused when full
               if (req_item.req_type == depq_pkg::OP_INSERT) begin
                  if (count_ff == CAP_COUNT) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.status = depq_pkg::ST_DROPPED;
                  end
               end else if (req_item.req_type inside {depq_pkg::OP_SERVE_HIGH,
                                                      depq_pkg::OP_SERVE_LOW}) begin
                  if (count_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.status = depq_pkg::ST_EMPTY;
                  end
               end
            end
         end
         depq_pkg::S_INS_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = head_ff;
               wr_data  = new_ff;
               count_in = count_ff + CW'(1);
            end else begin
               rd_addr = to_phys(head_ff, pos_ff - AW'(1));
            end
         end
         depq_pkg::S_INS_CMP: begin
            wr_en   = 1'b1;
            wr_addr = to_phys(head_ff, pos_ff);
            if (rd_data_ff.pri >= new_ff.pri) begin
               // shift the lower neighbor up one slot
               wr_data = rd_data_ff;
               pos_in  = pos_ff - AW'(1);
            end else begin
               wr_data  = new_ff;
               count_in = count_ff + CW'(1);
            end
         end
         depq_pkg::S_SRV_RD: begin
            if (op_ff == depq_pkg::OP_SERVE_LOW) begin
               rd_addr = head_ff;
            end else begin
               rd_addr = to_phys(head_ff, count_m1[AW-1:0]);
            end
         end
         depq_pkg::S_SRV_OUT: begin
            rsp_strobe_in    = 1'b1;
            rsp_in.served_id = rd_data_ff.id;
            rsp_in.status    = depq_pkg::ST_SERVED;
            count_in         = count_m1;
            if (op_ff == depq_pkg::OP_SERVE_LOW) begin
               head_in = to_phys(head_ff, AW'(1));
            end
         end
         default: ;
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= depq_pkg::S_IDLE;
         count_ff      <= '0;
         head_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      op_ff  <= op_in;
      new_ff <= new_in;
      rsp_ff <= rsp_in;
   end

   // entry memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // ---------------- assertions ----------------
   `DEPQ_ASSERT_SAME(a_count_range, 1'b1, count_ff <= CAP_COUNT,
      "entry count above capacity")
   `DEPQ_ASSERT_NEXT(a_full_drop,
      accept && req_item.req_type == depq_pkg::OP_INSERT && count_ff == CAP_COUNT,
      rsp_strobe && rsp_item.status == depq_pkg::ST_DROPPED && $stable(count_ff),
      "insert into full store not dropped")
   `DEPQ_ASSERT_NEXT(a_serve_count, state_ff == depq_pkg::S_SRV_OUT,
      count_ff == $past(count_ff) - CW'(1) && rsp_strobe,
      "serve did not remove exactly one entry")
   `DEPQ_ASSERT_NEXT(a_result_source, !rsp_strobe_in,
      !rsp_strobe, "result strobe without a cause")

endmodule

`default_nettype wire
